[rtl/ssdt_pkg.sv]
// Shared constants and types for the descending tagged selection sorter.
`default_nettype none

package ssdt_pkg;

	// Storage geometry.
	localparam int MAX_ENTRIES = 8;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	// Field widths.
	localparam int KEY_W = 32;
	localparam int TAG_W = 8;
	localparam int REC_W = KEY_W + TAG_W;

	// One stored record.
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	// Access request from the sequencer to the record memory.
	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		rec_t wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	// Result marking that travels alongside the memory read data.
	typedef struct packed {
		logic valid;
		logic last;
	} res_ctl_t;

endpackage

`default_nettype wire

[rtl/ssdt_ram.sv]
// Generic single-write, single-read synchronous memory with registered read data.
`default_nettype none

module ssdt_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 40
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port; a read of the entry written in the
	// same cycle returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/ssdt_ctrl.sv]
// Sequencer that loads, sorts in place and reads out the record memory.
`default_nettype none

module ssdt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [ssdt_pkg::KEY_W-1:0] key_value,
	input wire logic [ssdt_pkg::TAG_W-1:0] tag_id,
	input wire logic last_item,
	input wire ssdt_pkg::rec_t rdata,
	output ssdt_pkg::ram_req_t ram_req,
	output ssdt_pkg::res_ctl_t res_ctl,
	output logic busy
);

	import ssdt_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] addr_q;
	logic [IDX_W-1:0] start_q;
	logic rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic emit_vld_q;
	logic emit_last_q;

	rec_t best_q;
	rec_t cur_q;
	logic [IDX_W-1:0] best_idx_q;

	logic take;
	logic room;
	logic [CNT_W-1:0] cnt_next;
	logic [IDX_W-1:0] last_idx;
	logic [CNT_W:0] next_start_end;
	logic scan_done;

	// Request acceptance and the count after storing it.
	assign take = start && (state_q == ST_LOAD);
	assign room = (cnt_q < CNT_W'(MAX_ENTRIES));
	assign cnt_next = room ? (cnt_q + CNT_W'(1)) : cnt_q;
	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
	// Sorting continues while the next start position plus one is below the count.
	assign next_start_end = (CNT_W+1)'(start_q) + (CNT_W+1)'(2);
	assign scan_done = rd_vld_s1 && (rd_idx_s1 == last_idx);

	// Memory request: loads in the load state, swap writes in the two swap states.
	always_comb begin
		ram_req.we = 1'b0;
		ram_req.waddr = cnt_q[IDX_W-1:0];
		ram_req.wdata = '{key: key_value, tag: tag_id};
		ram_req.raddr = addr_q[IDX_W-1:0];
		case (state_q)
			ST_LOAD: begin
				ram_req.we = take && room;
			end
			ST_SWAP_A: begin
				ram_req.we = 1'b1;
				ram_req.waddr = best_idx_q;
				ram_req.wdata = cur_q;
			end
			ST_SWAP_B: begin
				ram_req.we = 1'b1;
				ram_req.waddr = start_q;
				ram_req.wdata = best_q;
			end
			default: begin
				ram_req.we = 1'b0;
			end
		endcase
	end

	// State, counters and the registered result marking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			addr_q <= '0;
			start_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			emit_vld_q <= 1'b0;
			emit_last_q <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= addr_q[IDX_W-1:0];
			emit_vld_q <= 1'b0;
			emit_last_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (take) begin
						cnt_q <= cnt_next;
						start_q <= '0;
						addr_q <= '0;
						if (last_item) begin
							state_q <= (cnt_next < CNT_W'(2)) ? ST_EMIT : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (addr_q < cnt_q) begin
						rd_vld_s1 <= 1'b1;
						addr_q <= addr_q + CNT_W'(1);
					end
					if (scan_done) begin
						state_q <= ST_SWAP_A;
					end
				end
				ST_SWAP_A: begin
					state_q <= ST_SWAP_B;
				end
				ST_SWAP_B: begin
					start_q <= start_q + IDX_W'(1);
					if (next_start_end < (CNT_W+1)'(cnt_q)) begin
						addr_q <= CNT_W'(start_q) + CNT_W'(1);
						state_q <= ST_SCAN;
					end else begin
						addr_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					emit_vld_q <= 1'b1;
					emit_last_q <= (addr_q[IDX_W-1:0] == last_idx);
					addr_q <= addr_q + CNT_W'(1);
					if (addr_q[IDX_W-1:0] == last_idx) begin
						cnt_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Running maximum of the current pass; the first read is the start record.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (rd_idx_s1 == start_q) begin
				best_q <= rdata;
				cur_q <= rdata;
				best_idx_q <= rd_idx_s1;
			end else if (rdata.key > best_q.key) begin
				best_q <= rdata;
				best_idx_q <= rd_idx_s1;
			end
		end
	end

	assign res_ctl = '{valid: emit_vld_q, last: emit_last_q};
	assign busy = (state_q != ST_LOAD);

endmodule

`default_nettype wire

[rtl/selection_sort_descending_tagged_unit.sv]
// Top level of the descending tagged selection sorter.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low; it carries key_value (signed), tag_id and last_item. Each request
// stores one record in the record memory. A request
// arriving with the memory already full is dropped, but its last_item still
// closes the set. Once the set is closed, busy rises and the block sorts the
// records in place in descending key order by selection sort, then reads
// them out largest key first.
// Each result is shown for one cycle with result_valid high, on sorted_key
// and sorted_tag; end_of_run marks the final record of the set. Results
// cannot be held off by the receiver and leave back to back, one per cycle.
// Sort passes for a set of n records: each pass from start position s
// scans records s to n - 1 through the single read port, then makes two
// swap writes through the single write port, for s from 0 to n - 2;
// readout then reads the records in order, the last result appearing in
// the same cycle as busy falls.
// Reset clears the record count and returns the block to loading; the
// memory contents are not cleared.
`default_nettype none

module selection_sort_descending_tagged_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [ssdt_pkg::KEY_W-1:0] key_value,
	input wire logic [ssdt_pkg::TAG_W-1:0] tag_id,
	input wire logic last_item,
	output logic result_valid,
	output logic signed [ssdt_pkg::KEY_W-1:0] sorted_key,
	output logic [ssdt_pkg::TAG_W-1:0] sorted_tag,
	output logic end_of_run
);

	import ssdt_pkg::*;

	ram_req_t ram_req;
	res_ctl_t res_ctl;
	rec_t rdata;
	logic [REC_W-1:0] rdata_raw;

	// Sequencer.
	ssdt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.key_value(key_value),
		.tag_id(tag_id),
		.last_item(last_item),
		.rdata(rdata),
		.ram_req(ram_req),
		.res_ctl(res_ctl),
		.busy(busy)
	);

	// Record memory.
	ssdt_ram #(
		.DEPTH(MAX_ENTRIES),
		.WIDTH(REC_W)
	) u_ram (
		.clk(clk),
		.we(ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.raddr(ram_req.raddr),
		.rdata(rdata_raw)
	);

	assign rdata = rdata_raw;

	// Result key and tag come straight from the registered read data.
	assign result_valid = res_ctl.valid;
	assign end_of_run = res_ctl.last;
	assign sorted_key = rdata.key;
	assign sorted_tag = rdata.tag;

	// A result is only produced by a readout issued while busy.
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a preceding busy cycle");

	// The end marker only comes with a result.
	a_last_with_valid: assert property (@(posedge clk) disable iff (!arst_n)
		end_of_run |-> result_valid)
		else $error("end_of_run without result_valid");

	// A closing request always starts the sort or readout.
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> busy)
		else $error("closing request did not raise busy");

	// Nothing is emitted in the cycle right after a closing request.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> !result_valid)
		else $error("result before any readout");

endmodule

`default_nettype wire
